@@ rtl/tgb_pkg.sv @@
package tgb_pkg;

  // shared multiplier operand: 24-bit corner values plus one delta bit
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;
  localparam int RES_W  = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int IN_MAX = 24;

  typedef logic signed [MUL_W-1:0] opnd_t;

  // one triangle, reduced to edge and texture deltas
  typedef struct packed {
    opnd_t q1x;
    opnd_t q1y;
    opnd_t q1z;
    opnd_t q2x;
    opnd_t q2y;
    opnd_t q2z;
    opnd_t du1;
    opnd_t dv1;
    opnd_t du2;
    opnd_t dv2;
  } tri_rec_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL,
    B_SIGN,
    B_LOAD,
    B_NORM,
    B_SQ,
    B_SQRT,
    B_DIVI,
    B_DIV,
    B_STORE,
    B_DONE
  } back_state_t;

endpackage

@@ rtl/triangle_tangent_binormal.sv @@
// Per-triangle tangent and binormal unit. Corners arrive one per beat: position
// (signed Q8.8) and texture coordinate (signed Q4.12); in_starts_triangle restarts
// the triangle, otherwise corners form consecutive triples. On each third corner
// the front forms edge and texture deltas and queues them (two triangles deep); the
// back runs them through one shared 25x25 multiplier (14 products, then three
// squares per vector after its normalization shift), a two-bit-per-cycle square
// root and a bit-serial divider with a setup and a store state per component.
// Results are unit vectors in signed Q1.14 with a degenerate flag; degenerate
// triangles return zero vectors. Corners are taken while the back works, until
// the queue holds two triangles.
module triangle_tangent_binormal #(
  parameter int POS_BITS = 16,
  parameter int TEX_BITS = 16,
  parameter int OUT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // corner beats
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [POS_BITS-1:0]        in_pos_x,
  input  logic [POS_BITS-1:0]        in_pos_y,
  input  logic [POS_BITS-1:0]        in_pos_z,
  input  logic [TEX_BITS-1:0]        in_tex_u,
  input  logic [TEX_BITS-1:0]        in_tex_v,
  input  logic                       in_starts_triangle,
  // result beats
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [OUT_BITS-1:0] out_tangent_x,
  output logic signed [OUT_BITS-1:0] out_tangent_y,
  output logic signed [OUT_BITS-1:0] out_tangent_z,
  output logic signed [OUT_BITS-1:0] out_binormal_x,
  output logic signed [OUT_BITS-1:0] out_binormal_y,
  output logic signed [OUT_BITS-1:0] out_binormal_z,
  output logic                       out_degenerate
);

  // front to queue
  logic              q_push;
  logic              q_full;
  tgb_pkg::tri_rec_t q_din;
  // queue to back
  logic              q_pop;
  logic              q_empty;
  tgb_pkg::tri_rec_t q_dout;
  // result register
  logic                       res_valid;
  logic signed [OUT_BITS-1:0] res_tan [3];
  logic signed [OUT_BITS-1:0] res_bin [3];

  // corner collection and delta formation
  tgb_front #(
    .POS_BITS (POS_BITS),
    .TEX_BITS (TEX_BITS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_tex_u           (in_tex_u),
    .in_tex_v           (in_tex_v),
    .in_starts_triangle (in_starts_triangle),
    .q_push             (q_push),
    .q_full             (q_full),
    .q_rec              (q_din)
  );

  // two-triangle decoupling queue
  tgb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .din   (q_din),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_dout)
  );

  // cross products, sign fix, normalization
  tgb_back #(
    .OUT_BITS (OUT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_rec     (q_dout),
    .res_valid (res_valid),
    .res_pop   (out_pop),
    .res_tan   (res_tan),
    .res_bin   (res_bin),
    .res_degen (out_degenerate)
  );

  assign out_empty      = !res_valid;
  assign out_tangent_x  = res_tan[0];
  assign out_tangent_y  = res_tan[1];
  assign out_tangent_z  = res_tan[2];
  assign out_binormal_x = res_bin[0];
  assign out_binormal_y = res_bin[1];
  assign out_binormal_z = res_bin[2];

endmodule

@@ rtl/tgb_queue.sv @@
module tgb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  tgb_pkg::tri_rec_t din,
  input  logic              pop,
  output logic              empty,
  output tgb_pkg::tri_rec_t dout
);

  tgb_pkg::tri_rec_t mem_r [2];
  logic              wp_r;
  logic              rp_r;
  logic [1:0]        cnt_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

@@ rtl/tgb_front.sv @@
module tgb_front #(
  parameter int POS_BITS = 16,
  parameter int TEX_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [POS_BITS-1:0] in_pos_x,
  input  logic [POS_BITS-1:0] in_pos_y,
  input  logic [POS_BITS-1:0] in_pos_z,
  input  logic [TEX_BITS-1:0] in_tex_u,
  input  logic [TEX_BITS-1:0] in_tex_v,
  input  logic                in_starts_triangle,
  output logic                q_push,
  input  logic                q_full,
  output tgb_pkg::tri_rec_t   q_rec
);

  localparam int PBE = (POS_BITS > tgb_pkg::IN_MAX) ? tgb_pkg::IN_MAX : POS_BITS;
  localparam int TBE = (TEX_BITS > tgb_pkg::IN_MAX) ? tgb_pkg::IN_MAX : TEX_BITS;

  tgb_pkg::opnd_t held_p_r [2][3];
  tgb_pkg::opnd_t held_t_r [2][2];
  logic [1:0]     count_r;
  logic [1:0]     slot;
  logic           accept;
  tgb_pkg::opnd_t px, py, pz, tu, tv;

  // corner values sign-extended from their low bits
  assign px = tgb_pkg::opnd_t'(signed'(in_pos_x[PBE-1:0]));
  assign py = tgb_pkg::opnd_t'(signed'(in_pos_y[PBE-1:0]));
  assign pz = tgb_pkg::opnd_t'(signed'(in_pos_z[PBE-1:0]));
  assign tu = tgb_pkg::opnd_t'(signed'(in_tex_u[TBE-1:0]));
  assign tv = tgb_pkg::opnd_t'(signed'(in_tex_v[TBE-1:0]));

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign slot    = in_starts_triangle ? 2'd0 : count_r;
  assign q_push  = accept && (slot == 2'd2);

  assign q_rec.q1x = held_p_r[1][0] - held_p_r[0][0];
  assign q_rec.q1y = held_p_r[1][1] - held_p_r[0][1];
  assign q_rec.q1z = held_p_r[1][2] - held_p_r[0][2];
  assign q_rec.q2x = px - held_p_r[0][0];
  assign q_rec.q2y = py - held_p_r[0][1];
  assign q_rec.q2z = pz - held_p_r[0][2];
  assign q_rec.du1 = held_t_r[1][0] - held_t_r[0][0];
  assign q_rec.dv1 = held_t_r[1][1] - held_t_r[0][1];
  assign q_rec.du2 = tu - held_t_r[0][0];
  assign q_rec.dv2 = tv - held_t_r[0][1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else if (accept) begin
      count_r <= (slot == 2'd2) ? 2'd0 : slot + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && slot != 2'd2) begin
      held_p_r[slot[0]][0] <= px;
      held_p_r[slot[0]][1] <= py;
      held_p_r[slot[0]][2] <= pz;
      held_t_r[slot[0]][0] <= tu;
      held_t_r[slot[0]][1] <= tv;
    end
  end

endmodule

@@ rtl/tgb_back.sv @@
module tgb_back #(
  parameter int OUT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  tgb_pkg::tri_rec_t          q_rec,
  output logic                       res_valid,
  input  logic                       res_pop,
  output logic signed [OUT_BITS-1:0] res_tan [3],
  output logic signed [OUT_BITS-1:0] res_bin [3],
  output logic                       res_degen
);

  localparam int QW  = OUT_BITS;
  localparam int NSH = OUT_BITS + 5;
  localparam int DW  = $clog2(QW);
  localparam logic [63:0] U64 = 64'(1) << (OUT_BITS - 2);
  localparam int RW  = tgb_pkg::RES_W;
  localparam int MW  = tgb_pkg::MAG_W;
  localparam int PW  = tgb_pkg::PROD_W;

  tgb_pkg::back_state_t state_r, state_nxt;
  tgb_pkg::tri_rec_t    rec_r;
  logic [3:0]           k_r;
  logic [3:0]           km1;
  logic signed [PW-1:0] prod_r, hold_r, mul_p;
  logic signed [RW-1:0] diff;
  logic signed [RW-1:0] det_r;
  logic signed [RW-1:0] tg_r [3];
  logic signed [RW-1:0] bn_r [3];
  logic                 degen_r;
  logic                 vsel_r;
  logic [1:0]           comp_r;
  logic [MW-1:0]        mag_r [3];
  logic [MW-1:0]        mmax;
  logic [MW-1:0]        s_r, s_sum;
  logic [63:0]          x_r, r_r, bit_r, sq_t;
  logic [63:0]          rem_r, dsh_r;
  logic [QW-1:0]        qt_r;
  logic [DW-1:0]        dcnt_r;
  logic signed [OUT_BITS-1:0] tan_r [3];
  logic signed [OUT_BITS-1:0] bin_r [3];
  logic                 res_load;
  tgb_pkg::opnd_t       mul_a, mul_b;
  logic [23:0]          mag_sel;
  logic                 cneg;
  logic [OUT_BITS-1:0]  qc;
  logic                 det_neg, tg_zero, bn_zero;

  assign km1     = k_r - 4'd1;
  assign diff    = {hold_r[PW-1], hold_r} - {prod_r[PW-1], prod_r};
  assign mul_p   = mul_a * mul_b;
  assign s_sum   = s_r + prod_r[MW-1:0];
  assign sq_t    = r_r + bit_r;
  assign det_neg = det_r[RW-1];
  assign tg_zero = (tg_r[0] == '0) && (tg_r[1] == '0) && (tg_r[2] == '0);
  assign bn_zero = (bn_r[0] == '0) && (bn_r[1] == '0) && (bn_r[2] == '0);
  assign qc      = (64'(qt_r) > U64) ? OUT_BITS'(U64) : OUT_BITS'(qt_r);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == tgb_pkg::B_SQ) begin
      case (k_r)
        4'd0: begin
          mul_a = tgb_pkg::opnd_t'({1'b0, mag_r[0][23:0]});
        end
        4'd1: begin
          mul_a = tgb_pkg::opnd_t'({1'b0, mag_r[1][23:0]});
        end
        4'd2: begin
          mul_a = tgb_pkg::opnd_t'({1'b0, mag_r[2][23:0]});
        end
        default: begin
          mul_a = '0;
        end
      endcase
      mul_b = mul_a;
    end else begin
      case (k_r)
        4'd0:  begin mul_a = rec_r.du1; mul_b = rec_r.dv2; end
        4'd1:  begin mul_a = rec_r.du2; mul_b = rec_r.dv1; end
        4'd2:  begin mul_a = rec_r.dv2; mul_b = rec_r.q1x; end
        4'd3:  begin mul_a = rec_r.dv1; mul_b = rec_r.q2x; end
        4'd4:  begin mul_a = rec_r.dv2; mul_b = rec_r.q1y; end
        4'd5:  begin mul_a = rec_r.dv1; mul_b = rec_r.q2y; end
        4'd6:  begin mul_a = rec_r.dv2; mul_b = rec_r.q1z; end
        4'd7:  begin mul_a = rec_r.dv1; mul_b = rec_r.q2z; end
        4'd8:  begin mul_a = rec_r.du1; mul_b = rec_r.q2x; end
        4'd9:  begin mul_a = rec_r.du2; mul_b = rec_r.q1x; end
        4'd10: begin mul_a = rec_r.du1; mul_b = rec_r.q2y; end
        4'd11: begin mul_a = rec_r.du2; mul_b = rec_r.q1y; end
        4'd12: begin mul_a = rec_r.du1; mul_b = rec_r.q2z; end
        4'd13: begin mul_a = rec_r.du2; mul_b = rec_r.q1z; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  always_comb begin
    mmax = mag_r[0];
    if (mag_r[1] > mmax) mmax = mag_r[1];
    if (mag_r[2] > mmax) mmax = mag_r[2];
  end

  always_comb begin
    mag_sel = '0;
    cneg    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (comp_r == 2'(i)) begin
        mag_sel = mag_r[i][23:0];
        cneg    = vsel_r ? bn_r[i][RW-1] : tg_r[i][RW-1];
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tgb_pkg::B_IDLE:  if (!q_empty) state_nxt = tgb_pkg::B_MUL;
      tgb_pkg::B_MUL:   if (k_r == 4'd14) state_nxt = tgb_pkg::B_SIGN;
      tgb_pkg::B_SIGN:  state_nxt = tgb_pkg::B_LOAD;
      tgb_pkg::B_LOAD:  state_nxt = degen_r ? tgb_pkg::B_DONE : tgb_pkg::B_NORM;
      tgb_pkg::B_NORM: begin
        if (mmax[MW-1:24] == '0 && mmax[23]) state_nxt = tgb_pkg::B_SQ;
      end
      tgb_pkg::B_SQ:    if (k_r == 4'd3) state_nxt = tgb_pkg::B_SQRT;
      tgb_pkg::B_SQRT:  if (bit_r[0]) state_nxt = tgb_pkg::B_DIVI;
      tgb_pkg::B_DIVI:  state_nxt = tgb_pkg::B_DIV;
      tgb_pkg::B_DIV:   if (dcnt_r == '0) state_nxt = tgb_pkg::B_STORE;
      tgb_pkg::B_STORE: begin
        if (comp_r != 2'd2) begin
          state_nxt = tgb_pkg::B_DIVI;
        end else if (!vsel_r) begin
          state_nxt = tgb_pkg::B_LOAD;
        end else begin
          state_nxt = tgb_pkg::B_DONE;
        end
      end
      tgb_pkg::B_DONE:  if (res_load) state_nxt = tgb_pkg::B_IDLE;
      default:          state_nxt = tgb_pkg::B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    res_load = 1'b0;
    case (state_r)
      tgb_pkg::B_IDLE: q_pop = !q_empty;
      tgb_pkg::B_DONE: res_load = !res_valid || res_pop;
      default: begin
        q_pop    = 1'b0;
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tgb_pkg::B_IDLE;
      res_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tgb_pkg::B_IDLE: begin
        rec_r <= q_rec;
        k_r   <= 4'd0;
      end
      tgb_pkg::B_MUL: begin
        if (k_r < 4'd14) prod_r <= mul_p;
        if (k_r != 4'd0) begin
          if (!km1[0]) begin
            hold_r <= prod_r;
          end else begin
            case (km1[3:1])
              3'd0: det_r    <= diff;
              3'd1: tg_r[0]  <= diff;
              3'd2: tg_r[1]  <= diff;
              3'd3: tg_r[2]  <= diff;
              3'd4: bn_r[0]  <= diff;
              3'd5: bn_r[1]  <= diff;
              3'd6: bn_r[2]  <= diff;
              default: hold_r <= hold_r;
            endcase
          end
        end
        k_r <= k_r + 4'd1;
      end
      tgb_pkg::B_SIGN: begin
        // sign of det stands in for the reciprocal
        for (int i = 0; i < 3; i++) begin
          tg_r[i] <= det_neg ? -tg_r[i] : tg_r[i];
          bn_r[i] <= det_neg ? -bn_r[i] : bn_r[i];
        end
        degen_r <= (det_r == '0) || tg_zero || bn_zero;
        vsel_r  <= 1'b0;
      end
      tgb_pkg::B_LOAD: begin
        if (degen_r) begin
          for (int i = 0; i < 3; i++) begin
            tan_r[i] <= '0;
            bin_r[i] <= '0;
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (vsel_r) begin
              mag_r[i] <= bn_r[i][RW-1] ? MW'(-bn_r[i]) : MW'(bn_r[i]);
            end else begin
              mag_r[i] <= tg_r[i][RW-1] ? MW'(-tg_r[i]) : MW'(tg_r[i]);
            end
          end
        end
      end
      tgb_pkg::B_NORM: begin
        // bring the largest magnitude into [2^23, 2^24)
        for (int i = 0; i < 3; i++) begin
          if (mmax[MW-1:28] != '0) begin
            mag_r[i] <= mag_r[i] >> 4;
          end else if (mmax[MW-1:24] != '0) begin
            mag_r[i] <= mag_r[i] >> 1;
          end else if (mmax[23:19] == '0) begin
            mag_r[i] <= mag_r[i] << 4;
          end else if (!mmax[23]) begin
            mag_r[i] <= mag_r[i] << 1;
          end
        end
        s_r <= '0;
        k_r <= 4'd0;
      end
      tgb_pkg::B_SQ: begin
        if (k_r < 4'd3) prod_r <= mul_p;
        if (k_r != 4'd0) s_r <= s_sum;
        k_r   <= k_r + 4'd1;
        x_r   <= 64'(s_sum) << 12;
        r_r   <= '0;
        bit_r <= 64'(1) << 62;
      end
      tgb_pkg::B_SQRT: begin
        if (x_r >= sq_t) begin
          x_r <= x_r - sq_t;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        comp_r <= 2'd0;
      end
      tgb_pkg::B_DIVI: begin
        rem_r  <= (64'(mag_sel) << NSH) + r_r;
        dsh_r  <= r_r << QW;
        qt_r   <= '0;
        dcnt_r <= DW'(QW - 1);
      end
      tgb_pkg::B_DIV: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
        end
        qt_r   <= {qt_r[QW-2:0], (rem_r >= dsh_r)};
        dsh_r  <= dsh_r >> 1;
        dcnt_r <= dcnt_r - DW'(1);
      end
      tgb_pkg::B_STORE: begin
        for (int i = 0; i < 3; i++) begin
          if (comp_r == 2'(i)) begin
            if (vsel_r) begin
              bin_r[i] <= cneg ? -signed'(qc) : signed'(qc);
            end else begin
              tan_r[i] <= cneg ? -signed'(qc) : signed'(qc);
            end
          end
        end
        if (comp_r == 2'd2) begin
          vsel_r <= 1'b1;
        end
        comp_r <= comp_r + 2'd1;
      end
      tgb_pkg::B_DONE: begin
        if (res_load) begin
          res_tan   <= tan_r;
          res_bin   <= bin_r;
          res_degen <= degen_r;
        end
      end
      default: begin
        k_r <= k_r;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_degen |-> res_tan[0] == '0 && res_tan[1] == '0 &&
      res_tan[2] == '0 && res_bin[0] == '0 && res_bin[1] == '0 && res_bin[2] == '0)
    else $error("degenerate result with nonzero vector");

  a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tgb_pkg::B_SQRT |-> $onehot(bit_r))
    else $error("square root bit lost");

  a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tgb_pkg::B_NORM |-> mmax != '0)
    else $error("normalizing a zero vector");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tgb_pkg::B_STORE |-> 64'(qt_r) <= U64)
    else $error("quotient above unit");
`endif

endmodule

@@ test/tgb_checker.sv @@
`timescale 1ns / 100ps

module tgb_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic signed [15:0] in_tex_u,
  input  logic signed [15:0] in_tex_v,
  input  logic               in_starts_triangle,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic signed [15:0] out_tangent_x,
  input  logic signed [15:0] out_tangent_y,
  input  logic signed [15:0] out_tangent_z,
  input  logic signed [15:0] out_binormal_x,
  input  logic signed [15:0] out_binormal_y,
  input  logic signed [15:0] out_binormal_z,
  input  logic               out_degenerate,
  output int                 fail_count,
  output int                 frames_pending
);

  typedef struct packed {
    logic signed [15:0] tx, ty, tz, bx, by, bz;
    logic               degen;
  } frame_t;

  frame_t frame_q[$];
  logic [1:0] corners_held;
  longint held_pos[2][3];
  longint held_uv[2][2];

  assign frames_pending = frame_q.size();

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // scale into [2^23, 2^24), then divide by the root of the square sum
  function automatic void make_unit(input longint c[3], output logic signed [15:0] o[3]);
    longint unsigned mag[3], top, ssum, f, q;
    top = 0;
    ssum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i] < 0 ? -c[i] : c[i];
      if (mag[i] > top) top = mag[i];
    end
    while (top >= (64'd1 << 24)) begin
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
      top >>= 1;
    end
    while (top < (64'd1 << 23)) begin
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
      top <<= 1;
    end
    for (int i = 0; i < 3; i++) ssum += mag[i] * mag[i];
    f = root64(ssum << 12);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 64'd16384 * 128 + f) / (2 * f);
      if (q > 16384) q = 16384;
      o[i] = c[i] < 0 ? -$signed(q[15:0]) : q[15:0];
    end
  endfunction

  task automatic take_corner();
    longint p[3], t[2], q1[3], q2[3], tg[3], bn[3];
    longint du1, dv1, du2, dv2, det;
    logic signed [15:0] ot[3], ob[3];
    frame_t fr;
    p[0] = in_pos_x; p[1] = in_pos_y; p[2] = in_pos_z;
    t[0] = in_tex_u; t[1] = in_tex_v;
    if (in_starts_triangle) corners_held = 0;
    if (corners_held < 2) begin
      held_pos[corners_held] = p;
      held_uv[corners_held] = t;
      corners_held++;
      return;
    end
    corners_held = 0;
    for (int i = 0; i < 3; i++) begin
      q1[i] = held_pos[1][i] - held_pos[0][i];
      q2[i] = p[i] - held_pos[0][i];
    end
    du1 = held_uv[1][0] - held_uv[0][0];
    dv1 = held_uv[1][1] - held_uv[0][1];
    du2 = t[0] - held_uv[0][0];
    dv2 = t[1] - held_uv[0][1];
    det = du1 * dv2 - du2 * dv1;
    for (int i = 0; i < 3; i++) begin
      tg[i] = dv2 * q1[i] - dv1 * q2[i];
      bn[i] = du1 * q2[i] - du2 * q1[i];
      if (det < 0) begin
        tg[i] = -tg[i];
        bn[i] = -bn[i];
      end
    end
    fr = '0;
    if (det == 0 || (tg[0] == 0 && tg[1] == 0 && tg[2] == 0) ||
        (bn[0] == 0 && bn[1] == 0 && bn[2] == 0)) begin
      fr.degen = 1'b1;
    end else begin
      make_unit(tg, ot);
      make_unit(bn, ob);
      fr.tx = ot[0]; fr.ty = ot[1]; fr.tz = ot[2];
      fr.bx = ob[0]; fr.by = ob[1]; fr.bz = ob[2];
    end
    frame_q.insert(frame_q.size(), fr);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    frame_t w;
    if (!rst_n) begin
      corners_held = 0;
    end else begin
      if (in_push && !in_full) take_corner();
      if (out_pop && !out_empty) begin
        if (frame_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          w = frame_q.pop_front();
          if (out_tangent_x != w.tx) report_mismatch("tangent_x", out_tangent_x, w.tx);
          if (out_tangent_y != w.ty) report_mismatch("tangent_y", out_tangent_y, w.ty);
          if (out_tangent_z != w.tz) report_mismatch("tangent_z", out_tangent_z, w.tz);
          if (out_binormal_x != w.bx) report_mismatch("binormal_x", out_binormal_x, w.bx);
          if (out_binormal_y != w.by) report_mismatch("binormal_y", out_binormal_y, w.by);
          if (out_binormal_z != w.bz) report_mismatch("binormal_z", out_binormal_z, w.bz);
          if (out_degenerate != w.degen) report_mismatch("degenerate", out_degenerate, w.degen);
        end
      end
    end
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [15:0] in_pos_x, in_pos_y, in_pos_z, in_tex_u, in_tex_v;
  logic        in_starts_triangle;
  logic        out_empty;
  logic        out_pop;
  logic signed [15:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic signed [15:0] out_binormal_x, out_binormal_y, out_binormal_z;
  logic        out_degenerate;
  int          fail_count;
  int          frames_pending;
  bit          steady;  // no idling on either side while set

  triangle_tangent_binormal dut (.*);

  tgb_checker chk (.*);

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard limit: far longer than ~650 triangles need
  initial begin
    #60ms;
    $display("Regression FAIL");
    $finish;
  end

  // result side pops at random unless steady is set, about 20 percent of cycles stalled
  initial begin
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      out_pop <= steady || ($urandom_range(99) >= 20);
    end
  end

  // one corner beat, held until accepted; push stays high into the next beat
  task automatic send_corner(input logic [15:0] px, py, pz, tu, tv, input logic st);
    while (!steady && $urandom_range(99) < 20) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    in_tex_u <= tu; in_tex_v <= tv;
    in_starts_triangle <= st;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_word();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(15));
      3: return -16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_triangle(input logic [15:0] p[3][3], input logic [15:0] t[3][2]);
    for (int k = 0; k < 3; k++)
      send_corner(p[k][0], p[k][1], p[k][2], t[k][0], t[k][1], k == 0);
  endtask

  initial begin
    logic [15:0] p[3][3];
    logic [15:0] t[3][2];
    int sent;
    steady = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_pos_x = '0; in_pos_y = '0; in_pos_z = '0;
    in_tex_u = '0; in_tex_v = '0;
    in_starts_triangle = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plain right triangle with unit texture mapping
    p = '{'{16'h0, 16'h0, 16'h0}, '{16'h100, 16'h0, 16'h0}, '{16'h0, 16'h100, 16'h0}};
    t = '{'{16'h0, 16'h0}, '{16'h1000, 16'h0}, '{16'h0, 16'h1000}};
    send_triangle(p, t);
    // mirrored mapping, negative determinant
    t = '{'{16'h0, 16'h0}, '{16'h0, 16'h1000}, '{16'h1000, 16'h0}};
    send_triangle(p, t);
    // zero determinant: all texcoords equal
    t = '{'{16'h7fff, 16'h8000}, '{16'h7fff, 16'h8000}, '{16'h7fff, 16'h8000}};
    send_triangle(p, t);
    // collapsed positions, good texcoords: zero vectors
    p = '{'{16'h8000, 16'h7fff, 16'h8000}, '{16'h8000, 16'h7fff, 16'h8000},
          '{16'h8000, 16'h7fff, 16'h8000}};
    t = '{'{16'h0, 16'h0}, '{16'h1000, 16'h0}, '{16'h0, 16'h1000}};
    send_triangle(p, t);
    // extreme spans on every axis
    p = '{'{16'h8000, 16'h8000, 16'h8000}, '{16'h7fff, 16'h8000, 16'h7fff},
          '{16'h8000, 16'h7fff, 16'h7fff}};
    t = '{'{16'h8000, 16'h8000}, '{16'h7fff, 16'h8000}, '{16'h8000, 16'h7fff}};
    send_triangle(p, t);
    // restart mid-triangle, then unmarked corners cut into triples
    send_corner(16'h10, 16'h20, 16'h30, 16'h1, 16'h2, 1'b1);
    send_corner(16'h40, 16'h50, 16'h60, 16'h3, 16'h4, 1'b0);
    for (int k = 0; k < 6; k++)
      send_corner(rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), k == 0);
    in_push <= 1'b0;

    // drain pause: wait out every expected result
    while (frames_pending != 0) @(posedge clk);

    sent = 0;
    while (sent < 1900) begin
      steady = (sent >= 600 && sent < 800);
      if ($urandom_range(9) == 0) begin
        // noise: random marks, breaks the triples
        send_corner(rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                    1'($urandom));
        sent++;
      end else begin
        for (int k = 0; k < 3; k++) begin
          for (int a = 0; a < 3; a++) p[k][a] = rnd_word();
          for (int a = 0; a < 2; a++) t[k][a] = rnd_word();
        end
        if ($urandom_range(19) == 0) t[2] = t[1];  // pushes toward degenerate
        send_triangle(p, t);
        sent += 3;
      end
    end
    steady = 1'b0;
    in_push <= 1'b0;

    // drain, then let the back end settle
    while (frames_pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
